// ===== rtl/core/arm_thumb_instruction_class_decoder_macros.svh =====
// Assertion macros for the ARM/Thumb instruction class decoder checker.
// No dependencies; included by the checker file.
`ifndef ARM_THUMB_INSTRUCTION_CLASS_DECODER_MACROS_SVH
`define ARM_THUMB_INSTRUCTION_CLASS_DECODER_MACROS_SVH

// Check a property on the rising clock edge, off while reset is low.
`define ATCD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("atcd assertion failed");

// Check that an antecedent is followed by a consequent, using non-overlapping implication (|=>).
`define ATCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    `ATCD_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`endif

// ===== rtl/core/atcd_pkg.sv =====
// Package for the ARM/Thumb instruction class decoder.
// Holds class codes, condition/ALU/shift constants, the decode result type and an ALU op helper.
package atcd_pkg;

    typedef enum logic [5:0] {
        CLS_UNDEF         = 6'd0,
        CLS_PRELOAD       = 6'd1,
        CLS_BX_REG        = 6'd2,
        CLS_CLZ           = 6'd3,
        CLS_BKPT          = 6'd4,
        CLS_QADDSUB       = 6'd5,
        CLS_SMLA_XY       = 6'd6,
        CLS_SMLAW_Y       = 6'd7,
        CLS_SMLAL_XY      = 6'd8,
        CLS_MUL           = 6'd9,
        CLS_MULL          = 6'd10,
        CLS_SWP           = 6'd11,
        CLS_HALF_XFER     = 6'd12,
        CLS_MRS           = 6'd13,
        CLS_MSR           = 6'd14,
        CLS_DATA_PROC     = 6'd15,
        CLS_SINGLE_XFER   = 6'd16,
        CLS_BLOCK_XFER    = 6'd17,
        CLS_BRANCH        = 6'd18,
        CLS_CP_DUAL       = 6'd19,
        CLS_CP_XFER       = 6'd20,
        CLS_CP_REG        = 6'd21,
        CLS_CP_DATA       = 6'd22,
        CLS_SWI           = 6'd23,
        CLS_T_ADD_SUB     = 6'd24,
        CLS_T_SHIFT_IMM   = 6'd25,
        CLS_T_MOV_CMP_IMM = 6'd26,
        CLS_T_ALU         = 6'd27,
        CLS_T_ALU_SHIFT   = 6'd28,
        CLS_T_ALU_NEG     = 6'd29,
        CLS_T_ALU_MUL     = 6'd30,
        CLS_T_HI_BX       = 6'd31,
        CLS_T_HI_OP       = 6'd32,
        CLS_T_PC_LOAD     = 6'd33,
        CLS_T_HALF_REG    = 6'd34,
        CLS_T_WORD_REG    = 6'd35,
        CLS_T_WORD_IMM    = 6'd36,
        CLS_T_HALF_IMM    = 6'd37,
        CLS_T_SP_XFER     = 6'd38,
        CLS_T_ADD_SP_PC   = 6'd39,
        CLS_T_ADJ_SP      = 6'd40,
        CLS_T_PUSH_POP    = 6'd41,
        CLS_T_LDM_STM     = 6'd42,
        CLS_T_BCOND       = 6'd43,
        CLS_T_B           = 6'd44,
        CLS_T_BL_PREFIX   = 6'd45,
        CLS_T_BL_SUFFIX   = 6'd46
    } t_instr_class;

    localparam logic [3:0] COND_AL = 4'd14;
    localparam logic [3:0] COND_NV = 4'd15;

    localparam logic [3:0] ALU_NONE = 4'd0;
    localparam logic [3:0] ALU_SUB  = 4'd2;
    localparam logic [3:0] ALU_RSB  = 4'd3;
    localparam logic [3:0] ALU_ADD  = 4'd4;
    localparam logic [3:0] ALU_CMP  = 4'd10;
    localparam logic [3:0] ALU_MOV  = 4'd13;

    localparam logic [3:0] TALU_LSL = 4'd2;
    localparam logic [3:0] TALU_LSR = 4'd3;
    localparam logic [3:0] TALU_ASR = 4'd4;
    localparam logic [3:0] TALU_ROR = 4'd7;
    localparam logic [3:0] TALU_NEG = 4'd9;
    localparam logic [3:0] TALU_MUL = 4'd13;

    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    typedef struct packed {
        t_instr_class cls;
        logic [3:0]   cond;
        logic         xl;
        logic [3:0]   alu;
        logic [1:0]   sh;
        logic         ext;
    } t_dec_res;

    function automatic logic [3:0] mov_cmp_add_sub_op(input logic [1:0] sel);
        logic [3:0] op;
        case (sel)
            2'd0:    op = ALU_MOV;
            2'd1:    op = ALU_CMP;
            2'd2:    op = ALU_ADD;
            default: op = ALU_SUB;
        endcase
        return op;
    endfunction

endpackage

// ===== rtl/core/atcd_arm_dec.sv =====
// ARM (32-bit) instruction class decode, ARMv4T or ARMv5TE.
// Depends on atcd_pkg.
module atcd_arm_dec (
    input  logic [31:0]        i_word,
    input  logic               i_v5,
    output atcd_pkg::t_dec_res o_res
);
    import atcd_pkg::*;

    logic [3:0] cond;
    logic [2:0] op;
    logic [4:0] hi;
    logic [3:0] lo;
    logic       nv;

    assign cond = i_word[31:28];
    assign op   = i_word[27:25];
    assign hi   = i_word[24:20];
    assign lo   = i_word[7:4];
    assign nv   = i_v5 && (cond == COND_NV);

    always_comb begin
        o_res      = '0;
        o_res.cls  = CLS_UNDEF;
        o_res.cond = nv ? COND_AL : cond;
        if (nv) begin
            case (op)
                3'd2, 3'd3: begin
                    o_res.cls = ((hi & 5'h17) == 5'h15) ? CLS_PRELOAD : CLS_UNDEF;
                end
                3'd5: begin
                    o_res.cls = CLS_BRANCH;
                    o_res.xl  = 1'b1;
                end
                3'd6: begin
                    o_res.cls = CLS_CP_XFER;
                    o_res.ext = 1'b1;
                end
                3'd7: begin
                    if (!i_word[24]) begin
                        o_res.cls = i_word[4] ? CLS_CP_REG : CLS_CP_DATA;
                        o_res.ext = 1'b1;
                    end
                end
                default: o_res.cls = CLS_UNDEF;
            endcase
        end else begin
            case (op)
                3'd0: begin
                    if (hi == 5'h12 && lo == 4'h1) begin
                        o_res.cls = CLS_BX_REG;
                    end else if (hi == 5'h12 && lo == 4'h3) begin
                        o_res.cls = i_v5 ? CLS_BX_REG : CLS_UNDEF;
                    end else if (hi == 5'h16 && lo == 4'h1) begin
                        o_res.cls = i_v5 ? CLS_CLZ : CLS_UNDEF;
                    end else if (hi == 5'h12 && lo == 4'h7) begin
                        o_res.cls = i_v5 ? CLS_BKPT : CLS_UNDEF;
                    end else if ((hi & 5'h19) == 5'h10 && lo == 4'h5) begin
                        o_res.cls = i_v5 ? CLS_QADDSUB : CLS_UNDEF;
                    end else if ((hi & 5'h19) == 5'h10 && (lo & 4'h9) == 4'h8) begin
                        if (!i_v5) begin
                            o_res.cls = CLS_UNDEF;
                        end else if (i_word[22:21] == 2'd1) begin
                            o_res.cls = CLS_SMLAW_Y;
                        end else if (i_word[22:21] == 2'd2) begin
                            o_res.cls = CLS_SMLAL_XY;
                        end else begin
                            o_res.cls = CLS_SMLA_XY;
                        end
                    end else if ((hi & 5'h1c) == 5'h00 && lo == 4'h9) begin
                        o_res.cls = CLS_MUL;
                    end else if ((hi & 5'h18) == 5'h08 && lo == 4'h9) begin
                        o_res.cls = CLS_MULL;
                    end else if ((hi & 5'h1b) == 5'h10 && lo == 4'h9) begin
                        o_res.cls = CLS_SWP;
                    end else if ((lo & 4'h9) == 4'h9) begin
                        if (i_word[20]) begin
                            o_res.cls = CLS_HALF_XFER;
                        end else if (i_word[6]) begin
                            o_res.cls = (i_v5 && i_word[12]) ? CLS_UNDEF : CLS_HALF_XFER;
                        end else if (i_word[5]) begin
                            o_res.cls = CLS_HALF_XFER;
                        end else begin
                            o_res.cls = CLS_UNDEF;
                        end
                    end else if ((hi & 5'h1b) == 5'h10 && lo == 4'h0) begin
                        o_res.cls = CLS_MRS;
                    end else if ((hi & 5'h1b) == 5'h12 && lo == 4'h0) begin
                        o_res.cls = CLS_MSR;
                    end else begin
                        o_res.cls = CLS_DATA_PROC;
                    end
                end
                3'd1: begin
                    if ((hi & 5'h1b) == 5'h12) begin
                        o_res.cls = CLS_MSR;
                    end else if ((hi & 5'h1b) == 5'h10) begin
                        o_res.cls = CLS_UNDEF;
                    end else begin
                        o_res.cls = CLS_DATA_PROC;
                    end
                end
                3'd2: o_res.cls = CLS_SINGLE_XFER;
                3'd3: o_res.cls = lo[0] ? CLS_UNDEF : CLS_SINGLE_XFER;
                3'd4: o_res.cls = CLS_BLOCK_XFER;
                3'd5: o_res.cls = CLS_BRANCH;
                3'd6: begin
                    o_res.cls = (i_v5 && (hi & 5'h1e) == 5'h04) ? CLS_CP_DUAL : CLS_CP_XFER;
                end
                default: begin
                    if (i_word[24]) begin
                        o_res.cls = CLS_SWI;
                    end else begin
                        o_res.cls = i_word[4] ? CLS_CP_REG : CLS_CP_DATA;
                    end
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/atcd_thumb_dec.sv =====
// Thumb (16-bit) instruction class decode, ARMv4T or ARMv5TE.
// Depends on atcd_pkg.
module atcd_thumb_dec (
    input  logic [15:0]        i_half,
    input  logic               i_v5,
    output atcd_pkg::t_dec_res o_res
);
    import atcd_pkg::*;

    logic [3:0] grp;
    logic [3:0] b8;
    logic [3:0] aop;

    assign grp = i_half[15:12];
    assign b8  = i_half[11:8];
    assign aop = i_half[9:6];

    always_comb begin
        o_res      = '0;
        o_res.cls  = CLS_UNDEF;
        o_res.cond = COND_AL;
        case (grp)
            4'd0, 4'd1: begin
                if (i_half[12:11] == 2'd3) begin
                    o_res.cls = CLS_T_ADD_SUB;
                    o_res.alu = i_half[9] ? ALU_SUB : ALU_ADD;
                end else begin
                    o_res.cls = CLS_T_SHIFT_IMM;
                    o_res.sh  = i_half[12:11];
                end
            end
            4'd2, 4'd3: begin
                o_res.cls = CLS_T_MOV_CMP_IMM;
                o_res.alu = mov_cmp_add_sub_op(i_half[12:11]);
            end
            4'd4: begin
                if (i_half[11:10] == 2'd0) begin
                    case (aop)
                        TALU_LSL: begin
                            o_res.cls = CLS_T_ALU_SHIFT;
                            o_res.alu = ALU_MOV;
                            o_res.sh  = SH_LSL;
                        end
                        TALU_LSR: begin
                            o_res.cls = CLS_T_ALU_SHIFT;
                            o_res.alu = ALU_MOV;
                            o_res.sh  = SH_LSR;
                        end
                        TALU_ASR: begin
                            o_res.cls = CLS_T_ALU_SHIFT;
                            o_res.alu = ALU_MOV;
                            o_res.sh  = SH_ASR;
                        end
                        TALU_ROR: begin
                            o_res.cls = CLS_T_ALU_SHIFT;
                            o_res.alu = ALU_MOV;
                            o_res.sh  = SH_ROR;
                        end
                        TALU_NEG: begin
                            o_res.cls = CLS_T_ALU_NEG;
                            o_res.alu = ALU_RSB;
                        end
                        TALU_MUL: o_res.cls = CLS_T_ALU_MUL;
                        default: begin
                            o_res.cls = CLS_T_ALU;
                            o_res.alu = aop;
                        end
                    endcase
                end else if (i_half[11:10] == 2'd1) begin
                    if (i_half[9:8] == 2'd3) begin
                        o_res.cls = CLS_T_HI_BX;
                        o_res.xl  = i_v5 && i_half[7];
                    end else begin
                        o_res.cls = CLS_T_HI_OP;
                    end
                end else begin
                    o_res.cls = CLS_T_PC_LOAD;
                end
            end
            4'd5:       o_res.cls = i_half[9] ? CLS_T_HALF_REG : CLS_T_WORD_REG;
            4'd6, 4'd7: o_res.cls = CLS_T_WORD_IMM;
            4'd8:       o_res.cls = CLS_T_HALF_IMM;
            4'd9:       o_res.cls = CLS_T_SP_XFER;
            4'd10:      o_res.cls = CLS_T_ADD_SP_PC;
            4'd11: begin
                case (b8)
                    4'd0:                    o_res.cls = CLS_T_ADJ_SP;
                    4'd14:                   o_res.cls = i_v5 ? CLS_BKPT : CLS_UNDEF;
                    4'd4, 4'd5, 4'd12, 4'd13: o_res.cls = CLS_T_PUSH_POP;
                    default:                 o_res.cls = CLS_UNDEF;
                endcase
            end
            4'd12: o_res.cls = CLS_T_LDM_STM;
            4'd13: begin
                o_res.cond = (b8 == COND_NV) ? COND_AL : b8;
                if (b8 == COND_AL) begin
                    o_res.cls = CLS_UNDEF;
                end else if (b8 == COND_NV) begin
                    o_res.cls = CLS_SWI;
                end else begin
                    o_res.cls = CLS_T_BCOND;
                end
            end
            4'd14: begin
                if (i_v5 && i_half[11]) begin
                    if (!i_half[0]) begin
                        o_res.cls = CLS_T_BL_SUFFIX;
                        o_res.xl  = 1'b1;
                    end
                end else begin
                    o_res.cls = CLS_T_B;
                end
            end
            default: o_res.cls = i_half[11] ? CLS_T_BL_SUFFIX : CLS_T_BL_PREFIX;
        endcase
    end

endmodule

// ===== rtl/core/arm_thumb_instruction_class_decoder.sv =====
// ARM/Thumb instruction class decoder: start passes through the input register,
// decode and result register to o_valid. Throughput one beat per cycle;
// busy stays low and o_valid pulses for one cycle per beat.
// Reset clears both valid flags and sets the architecture register to ARMv5TE.
// Depends on atcd_pkg, atcd_arm_dec and atcd_thumb_dec.
module arm_thumb_instruction_class_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_opcode,
    input  logic        i_thumb_mode,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    output logic        o_valid,
    output logic [5:0]  o_instr_class,
    output logic [3:0]  o_condition,
    output logic        o_exchange_or_link,
    output logic [3:0]  o_alu_op,
    output logic [1:0]  o_shift_kind,
    output logic        o_extension_space
);
    import atcd_pkg::*;

    logic        r_arch_v5te, n_arch_v5te;
    logic        r_in_vld, n_in_vld;
    logic [31:0] r_opcode, n_opcode;
    logic        r_thumb, n_thumb;
    logic        r_out_vld, n_out_vld;
    t_dec_res    r_res, n_res;
    t_dec_res    arm_res;
    t_dec_res    thumb_res;

    assign busy = 1'b0;

    atcd_arm_dec u_arm_dec (
        .i_word (r_opcode),
        .i_v5   (r_arch_v5te),
        .o_res  (arm_res)
    );

    atcd_thumb_dec u_thumb_dec (
        .i_half (r_opcode[15:0]),
        .i_v5   (r_arch_v5te),
        .o_res  (thumb_res)
    );

    always_comb begin
        n_arch_v5te = i_cfg_we ? i_cfg_wdata : r_arch_v5te;
        n_in_vld    = start && !busy;
        n_opcode    = n_in_vld ? i_opcode : r_opcode;
        n_thumb     = n_in_vld ? i_thumb_mode : r_thumb;
        n_out_vld   = r_in_vld;
        n_res       = r_in_vld ? (r_thumb ? thumb_res : arm_res) : r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arch_v5te <= 1'b1;
            r_in_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_arch_v5te <= n_arch_v5te;
            r_in_vld    <= n_in_vld;
            r_out_vld   <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_opcode <= n_opcode;
        r_thumb  <= n_thumb;
        r_res    <= n_res;
    end

    assign o_valid            = r_out_vld;
    assign o_instr_class      = r_res.cls;
    assign o_condition        = r_res.cond;
    assign o_exchange_or_link = r_res.xl;
    assign o_alu_op           = r_res.alu;
    assign o_shift_kind       = r_res.sh;
    assign o_extension_space  = r_res.ext;

endmodule

// ===== rtl/core/atcd_checker.sv =====
// Port-level checker for the ARM/Thumb instruction class decoder, with its bind.
// Depends on atcd_pkg and arm_thumb_instruction_class_decoder_macros.svh.
`include "arm_thumb_instruction_class_decoder_macros.svh"

module atcd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_thumb_mode,
    input logic        o_valid,
    input logic [3:0]  o_alu_op,
    input logic [1:0]  o_shift_kind,
    input logic        o_extension_space
);
    import atcd_pkg::*;

    `ATCD_ASSERT(a_beat_delivered, i_clk, i_rst_n, (start && !busy) |-> ##2 o_valid)
    `ATCD_ASSERT(a_no_spurious_beat, i_clk, i_rst_n, !(start && !busy) |-> ##2 !o_valid)
    `ATCD_ASSERT(a_thumb_no_ext, i_clk, i_rst_n,
        (start && !busy && i_thumb_mode) |-> ##2 !o_extension_space)
    `ATCD_ASSERT_NEXT(a_arm_no_thumb_fields, i_clk, i_rst_n,
        (start && !busy && !i_thumb_mode), ##1 (o_alu_op == ALU_NONE && o_shift_kind == SH_LSL))

endmodule

bind arm_thumb_instruction_class_decoder atcd_checker u_atcd_checker (.*);
